[rtl/tfds_pkg.sv]
// ----------------------------------------------------------------------------
// tfds_pkg
// Shared types, constants and helpers of the tent filter downscaler.
// ----------------------------------------------------------------------------
package tfds_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_FACTOR_DEF = 8;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int FACTOR_W   = 4;
  localparam int DIM_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIM_W-1:0]    RESET_DIM    = 12'd1500;
  localparam logic [FACTOR_W-1:0] RESET_FACTOR = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FACTOR = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // d^4 for d from 1 to 16
  function automatic logic [16:0] pow4(input logic [4:0] d);
    logic [16:0] r;
    case (d)
      5'd2:    r = 17'd16;
      5'd3:    r = 17'd81;
      5'd4:    r = 17'd256;
      5'd5:    r = 17'd625;
      5'd6:    r = 17'd1296;
      5'd7:    r = 17'd2401;
      5'd8:    r = 17'd4096;
      5'd9:    r = 17'd6561;
      5'd10:   r = 17'd10000;
      5'd11:   r = 17'd14641;
      5'd12:   r = 17'd20736;
      5'd13:   r = 17'd28561;
      5'd14:   r = 17'd38416;
      5'd15:   r = 17'd50625;
      5'd16:   r = 17'd65536;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

endpackage

[rtl/tfds_accum_mem.sv]
// ----------------------------------------------------------------------------
// tfds_accum_mem
// Accumulator store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tfds_accum_mem #(
  parameter int AW = 12,
  parameter int DW = 80
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/tfds_div.sv]
// ----------------------------------------------------------------------------
// tfds_div
// Four-channel restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfds_div import tfds_pkg::*; #(
  parameter int ACC_W = 20,
  parameter int D4W   = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] acc [4],
  input  logic [D4W-1:0]   d4,
  output div_stat_t        stat,
  output logic [PIX_W-1:0] quot [4]
);

  localparam int SW = D4W + PIX_W;
  localparam int BW = $clog2(PIX_W);

  logic [ACC_W-1:0] rem_r [4];
  logic [PIX_W-1:0] q_r [4];
  logic [BW-1:0]    bit_r;
  logic             busy_r;
  logic             done_r;
  logic [SW-1:0]    den;

  assign den = SW'(d4) << bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        bit_r  <= BW'(PIX_W - 1);
        for (int c = 0; c < 4; c++) begin
          rem_r[c] <= acc[c];
          q_r[c]   <= '0;
        end
      end else if (busy_r) begin
        for (int c = 0; c < 4; c++) begin
          if (SW'(rem_r[c]) >= den) begin
            rem_r[c]       <= ACC_W'(SW'(rem_r[c]) - den);
            q_r[c][bit_r]  <= 1'b1;
          end
        end
        if (bit_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          bit_r <= bit_r - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

[rtl/tent_filter_image_downscale_unit.sv]
// ----------------------------------------------------------------------------
// tent_filter_image_downscale_unit
// Tent filter image downscaler: RGBA raster in, decimated RGBA raster out.
//
//  channel | handshake                    | payload
//  in      | in_valid / in_ready          | in_red/green/blue/alpha, in_frame_start
//  out     | out_valid / out_ready        | out_red/green/blue/alpha, out_col,
//          |                              | out_row, out_frame_end
//  cfg     | cfg_we                       | cfg_index, cfg_wdata
//
// Factor 1: each item is passed straight to the output register. Otherwise
// each item visits the 4 window slots, with an accumulator read-modify-write
// for each slot it touches, and an item that closes an output pixel then runs
// the 8-step divider. Synchronous active-low reset; accumulators are not
// cleared. An output item waiting on out_ready holds the next result only.
// ----------------------------------------------------------------------------
module tent_filter_image_downscale_unit import tfds_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_FACTOR = MAX_FACTOR_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PIX_W-1:0]      in_red,
  input  logic [PIX_W-1:0]      in_green,
  input  logic [PIX_W-1:0]      in_blue,
  input  logic [PIX_W-1:0]      in_alpha,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_red,
  output logic [PIX_W-1:0]      out_green,
  output logic [PIX_W-1:0]      out_blue,
  output logic [PIX_W-1:0]      out_alpha,
  output logic [POS_W-1:0]      out_col,
  output logic [POS_W-1:0]      out_row,
  output logic                  out_frame_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DW    = $clog2(MAX_WIDTH + 1);
  localparam int FW    = $clog2(MAX_FACTOR + 1);
  localparam int ACC_W = $clog2(255 * MAX_FACTOR**4 + 1);
  localparam int D4W   = $clog2(MAX_FACTOR**4 + 1);
  localparam int AW    = CW + 1;
  localparam int WTW   = 2 * FW;
  localparam int MW    = CW + FW + 1;

  typedef enum logic [2:0] {S_IDLE, S_CHK, S_RD, S_WR, S_DIV, S_OUT} state_t;

  state_t state_r;

  // configuration
  logic [FACTOR_W-1:0] factor_r;
  logic [DIM_W-1:0]    width_r;
  logic [DIM_W-1:0]    height_r;
  logic                cfg_hit;
  logic [FW-1:0]       d_eff;
  logic [DW-1:0]       w_eff;
  logic [DW-1:0]       h_eff;

  always_comb begin
    case (cfg_index)
      CFG_FACTOR, CFG_WIDTH, CFG_HEIGHT: cfg_hit = cfg_we;
      default:                           cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= RESET_FACTOR;
      width_r  <= RESET_DIM;
      height_r <= RESET_DIM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FACTOR: factor_r <= cfg_wdata[FACTOR_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (factor_r == '0)                  d_eff = FW'(1);
    else if (int'(factor_r) > MAX_FACTOR) d_eff = FW'(MAX_FACTOR);
    else                                  d_eff = FW'(factor_r);
    if (width_r == '0)                   w_eff = DW'(1);
    else if (int'(width_r) > MAX_WIDTH)   w_eff = DW'(MAX_WIDTH);
    else                                  w_eff = DW'(width_r);
    if (height_r == '0)                  h_eff = DW'(1);
    else if (int'(height_r) > MAX_WIDTH)  h_eff = DW'(MAX_WIDTH);
    else                                  h_eff = DW'(height_r);
  end

  // position counters
  logic [CW-1:0] col_r, row_r, xq_r, yq_r;
  logic [FW-1:0] xm_r, ym_r;
  logic [CW-1:0] cx, cy, cxq, cyq;
  logic [FW-1:0] cxm, cym;
  logic [CW-1:0] col_nxt, row_nxt, xq_nxt, yq_nxt;
  logic [FW-1:0] xm_nxt, ym_nxt;
  logic          wrap, col_last, row_last;
  logic          accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    wrap = in_frame_start || (DW'(col_r) >= w_eff) || (DW'(row_r) >= h_eff);
    cx  = wrap ? '0 : col_r;
    cy  = wrap ? '0 : row_r;
    cxq = wrap ? '0 : xq_r;
    cyq = wrap ? '0 : yq_r;
    cxm = wrap ? '0 : xm_r;
    cym = wrap ? '0 : ym_r;
    col_last = (DW'(cx) + DW'(1) == w_eff);
    row_last = (DW'(cy) + DW'(1) == h_eff);
    col_nxt = cx + 1'b1;
    xq_nxt  = cxq;
    xm_nxt  = cxm + 1'b1;
    if (cxm + 1'b1 == d_eff) begin
      xm_nxt = '0;
      xq_nxt = cxq + 1'b1;
    end
    row_nxt = cy;
    yq_nxt  = cyq;
    ym_nxt  = cym;
    if (col_last) begin
      col_nxt = '0;
      xq_nxt  = '0;
      xm_nxt  = '0;
      if (row_last) begin
        row_nxt = '0;
        yq_nxt  = '0;
        ym_nxt  = '0;
      end else begin
        row_nxt = cy + 1'b1;
        ym_nxt  = cym + 1'b1;
        if (cym + 1'b1 == d_eff) begin
          ym_nxt = '0;
          yq_nxt = cyq + 1'b1;
        end
      end
    end
  end

  // item registers
  logic [PIX_W-1:0] pix_r [4];
  logic [CW-1:0]    ixq_r, iyq_r;
  logic [FW-1:0]    ixm_r, iym_r;

  // window slot evaluation; slot k: bit1 = row side, bit0 = column side
  logic [MW-1:0]  px1, px2, py1, py2, w1, h1;
  logic           u_ok [2];
  logic           v_ok [2];
  logic [FW-1:0]  wx [2];
  logic [FW-1:0]  wy [2];
  logic [CW-1:0]  ox [2];
  logic           oyp [2];
  logic           emit_c, fend_c;

  always_comb begin
    w1  = MW'(w_eff) + MW'(1);
    h1  = MW'(h_eff) + MW'(1);
    px1 = (MW'(ixq_r) + MW'(1)) * MW'(d_eff);
    px2 = (MW'(ixq_r) + MW'(2)) * MW'(d_eff);
    py1 = (MW'(iyq_r) + MW'(1)) * MW'(d_eff);
    py2 = (MW'(iyq_r) + MW'(2)) * MW'(d_eff);
    u_ok[0] = (ixq_r != '0) && ((FW+1)'(ixm_r) + (FW+1)'(2) <= (FW+1)'(d_eff)) && (px1 <= w1);
    u_ok[1] = (px2 <= w1);
    v_ok[0] = (iyq_r != '0) && ((FW+1)'(iym_r) + (FW+1)'(2) <= (FW+1)'(d_eff)) && (py1 <= h1);
    v_ok[1] = (py2 <= h1);
    wx[0]  = d_eff - FW'(1) - ixm_r;
    wx[1]  = ixm_r + FW'(1);
    wy[0]  = d_eff - FW'(1) - iym_r;
    wy[1]  = iym_r + FW'(1);
    ox[0]  = ixq_r - 1'b1;
    ox[1]  = ixq_r;
    oyp[0] = ~iyq_r[0];
    oyp[1] = iyq_r[0];
    emit_c = ((FW+1)'(ixm_r) + (FW+1)'(2) == (FW+1)'(d_eff)) &&
             ((FW+1)'(iym_r) + (FW+1)'(2) == (FW+1)'(d_eff)) && u_ok[0] && v_ok[0];
    fend_c = (px2 > w1) && (py2 > h1);
  end

  logic [WTW-1:0] wt_r [4];
  logic           ok_r [4];
  logic [AW-1:0]  addr_r [4];
  logic           first_r, emit_r;
  logic [1:0]     k_r;

  // accumulator datapath
  logic [ACC_W-1:0]   prod_r [4];
  logic [ACC_W-1:0]   sum [4];
  logic [ACC_W-1:0]   rd [4];
  logic [ACC_W-1:0]   cap_r [4];
  logic [4*ACC_W-1:0] rdata, wdata;
  logic               mem_re, mem_we, fin;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      rd[c]  = rdata[c*ACC_W +: ACC_W];
      sum[c] = (first_r && k_r == 2'd3) ? prod_r[c] : rd[c] + prod_r[c];
      wdata[c*ACC_W +: ACC_W] = sum[c];
    end
  end

  assign mem_re = (state_r == S_RD) && ok_r[k_r];
  assign mem_we = (state_r == S_WR);
  assign fin    = (k_r == 2'd3) && ((state_r == S_WR) || ((state_r == S_RD) && !ok_r[k_r]));

  tfds_accum_mem #(.AW(AW), .DW(4 * ACC_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r[k_r]),
    .wdata (wdata),
    .re    (mem_re),
    .raddr (addr_r[k_r]),
    .rdata (rdata)
  );

  div_stat_t        div_stat;
  logic [PIX_W-1:0] quot [4];
  logic             div_start;

  assign div_start = fin && emit_r;

  tfds_div #(.ACC_W(ACC_W), .D4W(D4W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .acc   (cap_r),
    .d4    (D4W'(pow4(5'(d_eff)))),
    .stat  (div_stat),
    .quot  (quot)
  );

  // pending result and output register
  logic [PIX_W-1:0] res_pix_r [4];
  logic [POS_W-1:0] res_col_r, res_row_r;
  logic             res_end_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] opix_r [4];
  logic [POS_W-1:0] ocol_r, orow_r;
  logic             oend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      xq_r        <= '0;
      yq_r        <= '0;
      xm_r        <= '0;
      ym_r        <= '0;
      k_r         <= '0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_hit) begin
        col_r <= '0;
        row_r <= '0;
        xq_r  <= '0;
        yq_r  <= '0;
        xm_r  <= '0;
        ym_r  <= '0;
      end else if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        xq_r  <= xq_nxt;
        yq_r  <= yq_nxt;
        xm_r  <= xm_nxt;
        ym_r  <= ym_nxt;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r[0] <= in_red;
            pix_r[1] <= in_green;
            pix_r[2] <= in_blue;
            pix_r[3] <= in_alpha;
            ixq_r    <= cxq;
            iyq_r    <= cyq;
            ixm_r    <= cxm;
            iym_r    <= cym;
            if (d_eff == FW'(1)) begin
              res_pix_r[0] <= in_red;
              res_pix_r[1] <= in_green;
              res_pix_r[2] <= in_blue;
              res_pix_r[3] <= in_alpha;
              res_col_r    <= POS_W'(cx);
              res_row_r    <= POS_W'(cy);
              res_end_r    <= col_last && row_last;
              state_r      <= S_OUT;
            end else begin
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          for (int k = 0; k < 4; k++) begin
            wt_r[k]   <= WTW'(wx[k % 2]) * WTW'(wy[k / 2]);
            ok_r[k]   <= u_ok[k % 2] && v_ok[k / 2];
            addr_r[k] <= {oyp[k / 2], ox[k % 2]};
          end
          first_r   <= (ixm_r == '0) && (iym_r == '0);
          emit_r    <= emit_c;
          res_col_r <= POS_W'(ox[0]);
          res_row_r <= POS_W'(iyq_r - 1'b1);
          res_end_r <= fend_c;
          k_r       <= '0;
          state_r   <= S_RD;
        end
        S_RD: begin
          if (ok_r[k_r]) begin
            for (int c = 0; c < 4; c++) begin
              prod_r[c] <= ACC_W'(wt_r[k_r]) * ACC_W'(pix_r[c]);
            end
            state_r <= S_WR;
          end else if (fin) begin
            state_r <= emit_r ? S_DIV : S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_WR: begin
          if (k_r == 2'd0) begin
            cap_r <= sum;
          end
          if (fin) begin
            state_r <= emit_r ? S_DIV : S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_pix_r <= quot;
            state_r   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            opix_r      <= res_pix_r;
            ocol_r      <= res_col_r;
            orow_r      <= res_row_r;
            oend_r      <= res_end_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = opix_r[0];
  assign out_green     = opix_r[1];
  assign out_blue      = opix_r[2];
  assign out_alpha     = opix_r[3];
  assign out_col       = ocol_r;
  assign out_row       = orow_r;
  assign out_frame_end = oend_r;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tent filter image downscaler. A directed table
// of pixels, then randomly filled frames under several factor and size
// settings (saturating, empty-output and full-width cases included), with
// random stalls on both channels. Results are checked against a bit-exact
// predictor of the window sums, or typed expectations for directed rows.
// ----------------------------------------------------------------------------
module tb_top import tfds_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = 2048;
  localparam int MAXF = 8;
  localparam int IDLE_LAT = 40;
  localparam int WDOG_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [PIX_W-1:0] r, g, b, a;
    logic [POS_W-1:0] col, row;
    logic             fe;
  } pix_res_t;

  typedef struct {
    logic [PIX_W-1:0] r, g, b, a;
    bit               fs;
    bit               typed;
    logic [POS_W-1:0] col;
  } dir_row_t;

  typedef struct {
    int f, w, h, n;
  } setting_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic [POS_W-1:0] out_col, out_row;
  logic out_frame_end;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tent_filter_image_downscale_unit DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  int unsigned m_factor = 1, m_width = 1500, m_height = 1500;
  int unsigned m_col = 0, m_row = 0;
  int unsigned win_acc [4][2*MAXW];

  pix_res_t out_pix_q[$];
  int err_cnt = 0;
  bit calm = 1'b0;

  function automatic int unsigned sat_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > MAXW) return MAXW;
    return v;
  endfunction

  function automatic int unsigned shrink(int unsigned n, int unsigned d);
    int unsigned q;
    q = (n + 1) / d;
    return q > 0 ? q - 1 : 0;
  endfunction

  function automatic bit tent_predict(input logic [PIX_W-1:0] r, g, b, a,
                                      input bit fs, output pix_res_t res);
    int unsigned d, w, h, x, y, wout, hout, xq, xm, yq, ym;
    int unsigned ox, oy, wx, wy, wt, idx, d4;
    int unsigned px[4];
    bit first;
    px[0] = r; px[1] = g; px[2] = b; px[3] = a;
    res = '0;
    d = (m_factor == 0) ? 1 : ((m_factor > MAXF) ? MAXF : m_factor);
    w = sat_dim(m_width);
    h = sat_dim(m_height);
    if (fs) begin m_col = 0; m_row = 0; end
    if (m_col >= w || m_row >= h) begin m_col = 0; m_row = 0; end
    x = m_col; y = m_row;
    m_col++;
    if (m_col >= w) begin
      m_col = 0;
      m_row++;
      if (m_row >= h) m_row = 0;
    end
    if (d == 1) begin
      res = '{r, g, b, a, x[POS_W-1:0], y[POS_W-1:0], (x == w-1 && y == h-1)};
      return 1'b1;
    end
    wout = shrink(w, d); hout = shrink(h, d);
    xq = x / d; xm = x % d; yq = y / d; ym = y % d;
    for (int v = 0; v < 2; v++) begin
      if (v == 1) begin
        oy = yq; wy = ym + 1;
      end else begin
        if (yq == 0 || ym > d - 2) continue;
        oy = yq - 1; wy = d - 1 - ym;
      end
      if (oy >= hout) continue;
      for (int u = 0; u < 2; u++) begin
        if (u == 1) begin
          ox = xq; wx = xm + 1;
        end else begin
          if (xq == 0 || xm > d - 2) continue;
          ox = xq - 1; wx = d - 1 - xm;
        end
        if (ox >= wout) continue;
        wt = wx * wy;
        idx = (oy & 1) * MAXW + ox;
        first = (v == 1 && ym == 0 && u == 1 && xm == 0);
        for (int c = 0; c < 4; c++)
          win_acc[c][idx] = first ? wt * px[c] : win_acc[c][idx] + wt * px[c];
      end
    end
    if (xm == d - 2 && ym == d - 2 && xq >= 1 && yq >= 1 &&
        xq - 1 < wout && yq - 1 < hout) begin
      ox = xq - 1; oy = yq - 1;
      d4 = d * d * d * d;
      idx = (oy & 1) * MAXW + ox;
      res.r = PIX_W'(win_acc[0][idx] / d4);
      res.g = PIX_W'(win_acc[1][idx] / d4);
      res.b = PIX_W'(win_acc[2][idx] / d4);
      res.a = PIX_W'(win_acc[3][idx] / d4);
      res.col = ox[POS_W-1:0];
      res.row = oy[POS_W-1:0];
      res.fe = (ox == wout - 1 && oy == hout - 1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int p;
    if (calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    if (p < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [PIX_W-1:0] rand_chan();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, a, input bit fs,
                            input bit typed, input pix_res_t typed_res);
    int gap;
    bit has;
    pix_res_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_red <= r; in_green <= g; in_blue <= b; in_alpha <= a;
    in_frame_start <= fs;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = tent_predict(r, g, b, a, fs, res);
    if (typed) res = typed_res;
    if (has) out_pix_q.push_back(res);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (out_pix_q.size() != 0) @(negedge clk);
    repeat (IDLE_LAT) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_FACTOR: begin m_factor = val & 4'hF; m_col = 0; m_row = 0; end
      CFG_WIDTH:  begin m_width = val & 12'hFFF; m_col = 0; m_row = 0; end
      CFG_HEIGHT: begin m_height = val & 12'hFFF; m_col = 0; m_row = 0; end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // output checker
  always @(posedge clk) begin
    pix_res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_red, out_green, out_blue, out_alpha, out_col, out_row, out_frame_end};
      if (out_pix_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected item: rgba %h %h %h %h col %0d row %0d end %b",
                   got.r, got.g, got.b, got.a, got.col, got.row, got.fe);
      end else begin
        want = out_pix_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch: exp rgba %h %h %h %h col %0d row %0d end %b",
                      " | got %h %h %h %h col %0d row %0d end %b"},
                     want.r, want.g, want.b, want.a, want.col, want.row, want.fe,
                     got.r, got.g, got.b, got.a, got.col, got.row, got.fe);
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int hold;
    bit cur;
    hold = 0;
    cur = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        if (cur) begin
          hold = pick_gap();
          if (hold > 0) cur = 1'b0;
          else hold = $urandom_range(1, 20);
        end else begin
          cur = 1'b1;
          hold = $urandom_range(1, 20);
        end
      end
      out_ready <= cur;
      hold--;
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      quiet <= 0;
    else if (quiet >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  initial begin
    dir_row_t dir_tab[10];
    setting_t plan[9];
    pix_res_t tr;
    int k, fsz;
    bit fs;

    // factor 1 after reset: pass-through, position counts from zero
    dir_tab[0] = '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 11'd0};
    dir_tab[1] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b1, 11'd1};
    dir_tab[2] = '{8'hAA, 8'h55, 8'hAA, 8'h55, 1'b0, 1'b1, 11'd2};
    dir_tab[3] = '{8'h55, 8'hAA, 8'h55, 8'hAA, 1'b1, 1'b1, 11'd0};
    dir_tab[4] = '{8'h01, 8'h80, 8'h7F, 8'hFE, 1'b0, 1'b1, 11'd1};
    dir_tab[5] = '{8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b0, 11'd0};
    dir_tab[6] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 11'd0};
    dir_tab[7] = '{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 11'd0};
    dir_tab[8] = '{8'h9C, 8'h3E, 8'hE1, 8'h07, 1'b0, 1'b0, 11'd0};
    dir_tab[9] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, 11'd0};

    plan[0] = '{2, 7, 7, 60};
    plan[1] = '{3, 11, 8, 50};
    plan[2] = '{6, 11, 11, 130};
    plan[3] = '{0, 0, 2, 20};
    plan[4] = '{15, 15, 15, 230};
    plan[5] = '{4, 5, 5, 30};
    plan[6] = '{2, 4095, 3, 30};
    plan[7] = '{2, 3, 4095, 20};
    plan[8] = '{5, 12, 14, 40};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      tr = '{dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].a,
             dir_tab[i].col, 11'd0, 1'b0};
      send_pixel(dir_tab[i].r, dir_tab[i].g, dir_tab[i].b, dir_tab[i].a,
                 dir_tab[i].fs, dir_tab[i].typed, tr);
    end
    drain_results();
    cfg_write(CFG_UNUSED, 12'hFFF);

    foreach (plan[p]) begin
      cfg_write(CFG_FACTOR, plan[p].f);
      cfg_write(CFG_WIDTH, plan[p].w);
      cfg_write(CFG_HEIGHT, plan[p].h);
      cfg_we <= 1'b0;
      @(negedge clk);
      fsz = sat_dim(plan[p].w) * sat_dim(plan[p].h);
      k = 0;
      for (int n = 0; n < plan[p].n; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        if (p == 0 && n == 30) drain_results();
        if ($urandom_range(0, 9) == 0) begin
          fs = ($urandom_range(0, 7) == 0);
          if (fs) k = 1;
        end else begin
          fs = (k == 0);
          k = (k + 1) % fsz;
        end
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), fs, 1'b0, '0);
      end
      drain_results();
    end

    if (err_cnt == 0 && out_pix_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
